// File: src/durz_pkg.sv
// Package: shared types and constants of the dual ultrasonic range and zone block.
`timescale 1ns / 1ps
package durz_pkg;

   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_TICKS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_SCALE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_LIMIT     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_LIMIT     = 3'd7;

   localparam logic [15:0] RST_TRIGGER_TICKS = 16'd1000;
   localparam logic [23:0] RST_ECHO_TIMEOUT  = 24'd1000000;
   localparam logic [23:0] RST_GAP_TICKS     = 24'd0;
   localparam logic [15:0] RST_TICK_SCALE    = 16'd2877;
   localparam logic [8:0]  RST_EMA_ALPHA     = 9'd51;
   localparam logic [9:0]  RST_NEAR_LIMIT    = 10'd10;
   localparam logic [9:0]  RST_MID_LIMIT     = 10'd30;
   localparam logic [9:0]  RST_FAR_LIMIT     = 10'd70;

   localparam logic [8:0] ALPHA_ONE = 9'd256;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_TRIG_MAIN = 3'd1;
   localparam logic [2:0] PH_TRIG_SUB  = 3'd2;
   localparam logic [2:0] PH_WAIT      = 3'd3;
   localparam logic [2:0] PH_ECHO      = 3'd4;
   localparam logic [2:0] PH_GAP       = 3'd5;

   localparam logic [1:0] ZONE_CLEAR  = 2'd0;
   localparam logic [1:0] ZONE_NEAR   = 2'd1;
   localparam logic [1:0] ZONE_MIDDLE = 2'd2;
   localparam logic [1:0] ZONE_FAR    = 2'd3;

   typedef struct packed {
      logic [15:0] trigger_ticks;
      logic [23:0] echo_timeout_ticks;
      logic [23:0] gap_ticks;
      logic [15:0] tick_scale;
      logic [8:0]  ema_alpha;
      logic [9:0]  near_limit_cm;
      logic [9:0]  mid_limit_cm;
      logic [9:0]  far_limit_cm;
   } durz_cfg_type;

   typedef struct packed {
      logic echo_main;
      logic echo_sub;
      logic accel_inhibit;
   } durz_req_type;

   typedef struct packed {
      logic        trig_main;
      logic        trig_sub;
      logic        result_valid;
      logic        timed_out;
      logic        measured_sensor;
      logic [17:0] filtered_distance;
      logic [1:0]  obstacle_zone;
      logic        sensor_select;
   } durz_rsp_type;

   typedef struct packed {
      logic         valid;
      durz_req_type beat;
   } durz_head_type;

endpackage

// File: src/durz_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface durz_req_if;
   logic valid;
   logic ready;
   logic echo_main;
   logic echo_sub;
   logic accel_inhibit;

   modport source (output valid, echo_main, echo_sub, accel_inhibit, input ready);
   modport sink (input valid, echo_main, echo_sub, accel_inhibit, output ready);
endinterface

interface durz_rsp_if;
   logic        valid;
   logic        ready;
   logic        trig_main;
   logic        trig_sub;
   logic        result_valid;
   logic        timed_out;
   logic        measured_sensor;
   logic [17:0] filtered_distance;
   logic [1:0]  obstacle_zone;
   logic        sensor_select;

   modport source (output valid, trig_main, trig_sub, result_valid, timed_out,
                   measured_sensor, filtered_distance, obstacle_zone, sensor_select,
                   input ready);
   modport sink (input valid, trig_main, trig_sub, result_valid, timed_out,
                 measured_sensor, filtered_distance, obstacle_zone, sensor_select,
                 output ready);
endinterface

// File: src/dual_ultrasonic_range_zone.sv
// Top level: dual ultrasonic echo ranger with per-sensor filter and obstacle zones.
//
// req_chan carries one beat per sampled clock tick: both echo pin levels and the
// inhibit flag. rsp_chan returns exactly one beat for every request beat, in order:
// trigger pin levels, the measurement result on the tick one completes, the held
// obstacle zone and the sensor selected for the next measurement.
// csr_we/csr_index/csr_wdata write the configuration registers; write them only
// while no request beat is outstanding.
// A completing tick takes registered steps in turn: the distance multiply, the
// filter multiplies and the zone compare into the response register.
// Throughput: one beat per cycle while the response is accepted; a completing
// tick holds the sequencer through the FIN_MUL, FIN_MIX and FIN_DONE steps.
// A two-entry queue sits between the input handshake and the sequencer.
// Reset: synchronous; sequencer idle, filters and zone cleared, main sensor
// selected, configuration back to its defaults.
// A stalled receiver holds the response register; the queue fills and
// req_chan.ready drops once both queue entries are held.
`timescale 1ns / 1ps
module dual_ultrasonic_range_zone
   import durz_pkg::*;
#(
   parameter int COUNT_BITS = 24,
   parameter int DIST_BITS  = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   durz_req_if.sink              req_chan,
   durz_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   durz_cfg_type  cfg_ff, cfg_in;
   durz_req_type  req_beat;
   durz_head_type head;
   logic          head_pop;
   logic          rsp_valid;
   durz_rsp_type  rsp_beat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRIGGER_TICKS: cfg_in.trigger_ticks      = csr_wdata[15:0];
            CSR_ECHO_TIMEOUT:  cfg_in.echo_timeout_ticks = csr_wdata[23:0];
            CSR_GAP_TICKS:     cfg_in.gap_ticks          = csr_wdata[23:0];
            CSR_TICK_SCALE:    cfg_in.tick_scale         = csr_wdata[15:0];
            CSR_EMA_ALPHA:     cfg_in.ema_alpha          = csr_wdata[8:0];
            CSR_NEAR_LIMIT:    cfg_in.near_limit_cm      = csr_wdata[9:0];
            CSR_MID_LIMIT:     cfg_in.mid_limit_cm       = csr_wdata[9:0];
            CSR_FAR_LIMIT:     cfg_in.far_limit_cm       = csr_wdata[9:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks      <= RST_TRIGGER_TICKS;
         cfg_ff.echo_timeout_ticks <= RST_ECHO_TIMEOUT;
         cfg_ff.gap_ticks          <= RST_GAP_TICKS;
         cfg_ff.tick_scale         <= RST_TICK_SCALE;
         cfg_ff.ema_alpha          <= RST_EMA_ALPHA;
         cfg_ff.near_limit_cm      <= RST_NEAR_LIMIT;
         cfg_ff.mid_limit_cm       <= RST_MID_LIMIT;
         cfg_ff.far_limit_cm       <= RST_FAR_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_beat.echo_main     = req_chan.echo_main;
   assign req_beat.echo_sub      = req_chan.echo_sub;
   assign req_beat.accel_inhibit = req_chan.accel_inhibit;

   durz_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_beat  (req_beat),
      .head     (head),
      .head_pop (head_pop)
   );

   durz_back #(
      .COUNT_BITS (COUNT_BITS),
      .DIST_BITS  (DIST_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .head_pop  (head_pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_chan.ready),
      .out_beat  (rsp_beat)
   );

   assign rsp_chan.valid             = rsp_valid;
   assign rsp_chan.trig_main         = rsp_beat.trig_main;
   assign rsp_chan.trig_sub          = rsp_beat.trig_sub;
   assign rsp_chan.result_valid      = rsp_beat.result_valid;
   assign rsp_chan.timed_out         = rsp_beat.timed_out;
   assign rsp_chan.measured_sensor   = rsp_beat.measured_sensor;
   assign rsp_chan.filtered_distance = rsp_beat.filtered_distance;
   assign rsp_chan.obstacle_zone     = rsp_beat.obstacle_zone;
   assign rsp_chan.sensor_select     = rsp_beat.sensor_select;

endmodule

// File: src/durz_front.sv
// Front end: accepts request beats into a two-entry queue ahead of the sequencer.
`timescale 1ns / 1ps
module durz_front
   import durz_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  durz_req_type  in_beat,
   output durz_head_type head,
   input  logic          head_pop
);

   durz_req_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;

   assign in_ready   = (count_ff != 2'd2);
   assign push       = in_valid && in_ready;
   assign head.valid = (count_ff != 2'd0);
   assign head.beat  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !head_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_beat;
      end
   end

endmodule

// File: src/durz_back.sv
// Back end: trigger/echo sequencer, distance filter pipeline and response register.
`timescale 1ns / 1ps
module durz_back
   import durz_pkg::*;
#(
   parameter int COUNT_BITS = 24,
   parameter int DIST_BITS  = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  durz_cfg_type  cfg,
   input  durz_head_type head,
   output logic          head_pop,
   output logic          out_valid,
   input  logic          out_ready,
   output durz_rsp_type  out_beat
);

   localparam int CW  = (COUNT_BITS > 24) ? COUNT_BITS : 24;
   localparam int PW  = COUNT_BITS + 16;
   localparam int DW  = (COUNT_BITS > DIST_BITS) ? COUNT_BITS : DIST_BITS;
   localparam int MW  = DIST_BITS + 9;
   localparam int SW  = DIST_BITS + 10;
   localparam int VW  = DIST_BITS + 2;
   localparam int ZW  = (DIST_BITS > 18) ? DIST_BITS : 18;
   localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
   localparam logic [DIST_BITS-1:0]  DIST_MAX = '1;

   localparam logic [1:0] FIN_IDLE = 2'd0;
   localparam logic [1:0] FIN_MUL  = 2'd1;
   localparam logic [1:0] FIN_MIX  = 2'd2;
   localparam logic [1:0] FIN_DONE = 2'd3;

   logic [2:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [COUNT_BITS-1:0] width_ff, width_in;
   logic [DIST_BITS-1:0]  filt_main_ff, filt_main_in;
   logic [DIST_BITS-1:0]  filt_sub_ff, filt_sub_in;
   logic [1:0]            zone_ff, zone_in;
   logic                  sensor_ff, sensor_in;
   logic [1:0]            fin_step_ff, fin_step_in;
   logic [COUNT_BITS-1:0] fin_width_ff;
   logic                  fin_tout_ff;
   logic [PW-1:0]         prod_ff;
   logic [MW-1:0]         pa_ff, pb_ff;
   logic                  out_valid_ff, out_valid_in;
   durz_rsp_type          out_ff, out_in;

   logic                  out_free;
   logic                  echo;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [23:0]           limit_sel;
   logic                  cnt_done;
   logic                  tm, ts, fin, fin_tout;
   logic [COUNT_BITS-1:0] fin_width;
   logic [DW-1:0]         dist_ext;
   logic [DIST_BITS-1:0]  dist_q;
   logic [8:0]            a_eff, a_inv;
   logic [DIST_BITS-1:0]  filt_old;
   logic [SW-1:0]         mix_sum;
   logic [VW-1:0]         v_raw;
   logic [DIST_BITS-1:0]  v;
   logic [1:0]            zone_new;
   logic                  flip;

   assign out_free  = !out_valid_ff || out_ready;
   assign head_pop  = head.valid && (fin_step_ff == FIN_IDLE) && out_free;
   assign out_valid = out_valid_ff;
   assign out_beat  = out_ff;
   assign echo      = sensor_ff ? head.beat.echo_sub : head.beat.echo_main;
   assign cnt_inc   = (tick_ff != CNT_MAX) ? tick_ff + COUNT_BITS'(1) : tick_ff;

   always_comb begin
      case (phase_ff)
         PH_WAIT: limit_sel = cfg.echo_timeout_ticks;
         PH_GAP:  limit_sel = cfg.gap_ticks;
         default: limit_sel = {8'd0, cfg.trigger_ticks};
      endcase
   end

   assign cnt_done = (CW'(cnt_inc) >= CW'(limit_sel)) || (cnt_inc == CNT_MAX);

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      width_in  = width_ff;
      tm        = 1'b0;
      ts        = 1'b0;
      fin       = 1'b0;
      fin_tout  = 1'b0;
      fin_width = width_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (!head.beat.accel_inhibit) begin
               phase_in = PH_TRIG_MAIN;
               tick_in  = '0;
            end
         end
         PH_TRIG_MAIN: begin
            tm      = 1'b1;
            tick_in = cnt_inc;
            if (cnt_done) begin
               phase_in = PH_TRIG_SUB;
               tick_in  = '0;
            end
         end
         PH_TRIG_SUB: begin
            ts      = 1'b1;
            tick_in = cnt_inc;
            if (cnt_done) begin
               phase_in = PH_WAIT;
               tick_in  = '0;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               width_in = COUNT_BITS'(1);
               phase_in = PH_ECHO;
            end else begin
               tick_in = cnt_inc;
               if (cnt_done) begin
                  fin       = 1'b1;
                  fin_tout  = 1'b1;
                  fin_width = '0;
               end
            end
         end
         PH_ECHO: begin
            if (echo) begin
               if (width_ff != CNT_MAX) begin
                  width_in = width_ff + COUNT_BITS'(1);
               end
            end else begin
               fin = 1'b1;
            end
         end
         PH_GAP: begin
            tick_in = cnt_inc;
            if (cnt_done) begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase
      if (fin) begin
         tick_in  = '0;
         width_in = '0;
         phase_in = (cfg.gap_ticks != 24'd0) ? PH_GAP : PH_IDLE;
      end
   end

   always_comb begin
      dist_ext = DW'(prod_ff[PW-1:16]);
      dist_q   = (dist_ext > DW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(dist_ext);
      a_eff    = (cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha;
      a_inv    = ALPHA_ONE - a_eff;
      filt_old = sensor_ff ? filt_sub_ff : filt_main_ff;
      mix_sum  = SW'(pa_ff) + SW'(pb_ff) + SW'(128);
      v_raw    = mix_sum[SW-1:8];
      v        = (v_raw > VW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(v_raw);
      flip     = 1'b0;
      if (ZW'(v) <= ZW'({cfg.near_limit_cm, 8'd0})) begin
         zone_new = ZONE_NEAR;
      end else if (ZW'(v) <= ZW'({cfg.mid_limit_cm, 8'd0})) begin
         zone_new = ZONE_MIDDLE;
      end else if (ZW'(v) <= ZW'({cfg.far_limit_cm, 8'd0})) begin
         zone_new = ZONE_FAR;
      end else begin
         zone_new = ZONE_CLEAR;
         flip     = 1'b1;
      end
   end

   always_comb begin
      fin_step_in  = fin_step_ff;
      filt_main_in = filt_main_ff;
      filt_sub_in  = filt_sub_ff;
      zone_in      = zone_ff;
      sensor_in    = sensor_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      case (fin_step_ff)
         FIN_IDLE: begin
            if (head_pop) begin
               if (fin) begin
                  fin_step_in = FIN_MUL;
               end else begin
                  out_valid_in           = 1'b1;
                  out_in                 = '0;
                  out_in.trig_main       = tm;
                  out_in.trig_sub        = ts;
                  out_in.obstacle_zone   = zone_ff;
                  out_in.sensor_select   = sensor_ff;
               end
            end
         end
         FIN_MUL: fin_step_in = FIN_MIX;
         FIN_MIX: fin_step_in = FIN_DONE;
         FIN_DONE: begin
            if (out_free) begin
               fin_step_in = FIN_IDLE;
               if (sensor_ff) begin
                  filt_sub_in = v;
               end else begin
                  filt_main_in = v;
               end
               zone_in                  = zone_new;
               sensor_in                = sensor_ff ^ flip;
               out_valid_in             = 1'b1;
               out_in.trig_main         = 1'b0;
               out_in.trig_sub          = 1'b0;
               out_in.result_valid      = 1'b1;
               out_in.timed_out         = fin_tout_ff;
               out_in.measured_sensor   = sensor_ff;
               out_in.filtered_distance = 18'(v);
               out_in.obstacle_zone     = zone_new;
               out_in.sensor_select     = sensor_ff ^ flip;
            end
         end
         default: fin_step_in = FIN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         width_ff     <= '0;
         filt_main_ff <= '0;
         filt_sub_ff  <= '0;
         zone_ff      <= ZONE_CLEAR;
         sensor_ff    <= 1'b0;
         fin_step_ff  <= FIN_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (head_pop) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            width_ff <= width_in;
         end
         filt_main_ff <= filt_main_in;
         filt_sub_ff  <= filt_sub_in;
         zone_ff      <= zone_in;
         sensor_ff    <= sensor_in;
         fin_step_ff  <= fin_step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (head_pop && fin) begin
         fin_width_ff <= fin_width;
         fin_tout_ff  <= fin_tout;
      end
      prod_ff <= PW'(fin_width_ff) * PW'(cfg.tick_scale);
      pa_ff   <= MW'(a_eff) * MW'(dist_q);
      pb_ff   <= MW'(a_inv) * MW'(filt_old);
   end

   a_tout_has_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.timed_out |-> out_ff.result_valid)
      else $error("timed_out without result_valid");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.result_valid |->
         out_ff.filtered_distance == 18'd0 && !out_ff.measured_sensor)
      else $error("result fields set on a beat without a result");

   a_one_trigger: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.trig_main && out_ff.trig_sub))
      else $error("both triggers driven");

   a_fin_advance: assert property (@(posedge clock) disable iff (reset)
      fin_step_ff == FIN_MUL |=> fin_step_ff == FIN_MIX)
      else $error("filter pipeline stalled in multiply step");

   a_result_no_trigger: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.result_valid |-> !out_ff.trig_main && !out_ff.trig_sub)
      else $error("trigger driven on a result beat");

endmodule

// File: tb/dual_ultrasonic_range_zone_tb.sv
// Testbench: checks all dual ultrasonic ranger response beats against a predictor or table.
`timescale 1ns / 1ps
module dual_ultrasonic_range_zone_tb;
   import durz_pkg::*;

   typedef struct packed {
      durz_req_type beat;
      logic [19:0]  reps;
      logic         typed;
      durz_rsp_type want;
   } drill_row_type;

   localparam durz_rsp_type QUIET = '0;
   localparam durz_rsp_type TRIG_MAIN_ONLY =
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 18'd0, ZONE_CLEAR, 1'b0};
   localparam durz_rsp_type TRIG_SUB_ONLY =
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 18'd0, ZONE_CLEAR, 1'b0};
   localparam durz_rsp_type FIRST_TIMEOUT =
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 18'd0, ZONE_NEAR, 1'b0};
   localparam durz_rsp_type HELD_NEAR =
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 18'd0, ZONE_NEAR, 1'b0};

   localparam int DRILL_ROWS = 22;
   localparam drill_row_type DRILL [DRILL_ROWS] = '{
      '{'{1'b0, 1'b0, 1'b1}, 20'd3,      1'b1, QUIET},
      '{'{1'b1, 1'b1, 1'b1}, 20'd1,      1'b1, QUIET},
      '{'{1'b0, 1'b0, 1'b0}, 20'd1,      1'b1, QUIET},
      '{'{1'b0, 1'b0, 1'b1}, 20'd1,      1'b1, TRIG_MAIN_ONLY},
      '{'{1'b1, 1'b1, 1'b0}, 20'd1,      1'b1, TRIG_SUB_ONLY},
      '{'{1'b0, 1'b0, 1'b0}, 20'd1,      1'b1, FIRST_TIMEOUT},
      '{'{1'b0, 1'b0, 1'b0}, 20'd1,      1'b1, HELD_NEAR},
      '{'{1'b0, 1'b0, 1'b0}, 20'd2,      1'b0, QUIET},
      '{'{1'b1, 1'b0, 1'b0}, 20'd600,    1'b0, QUIET},
      '{'{1'b0, 1'b1, 1'b0}, 20'd1,      1'b0, QUIET},
      '{'{1'b0, 1'b0, 1'b1}, 20'd1,      1'b0, QUIET},
      '{'{1'b0, 1'b0, 1'b0}, 20'd3,      1'b0, QUIET},
      '{'{1'b1, 1'b1, 1'b0}, 20'd300,    1'b0, QUIET},
      '{'{1'b1, 1'b0, 1'b0}, 20'd1,      1'b0, QUIET},
      '{'{1'b0, 1'b0, 1'b0}, 20'd3,      1'b0, QUIET},
      '{'{1'b0, 1'b1, 1'b0}, 20'd100,    1'b0, QUIET},
      '{'{1'b0, 1'b0, 1'b0}, 20'd1,      1'b0, QUIET},
      '{'{1'b1, 1'b0, 1'b0}, 20'd4,      1'b0, QUIET},
      '{'{1'b0, 1'b0, 1'b0}, 20'd3,      1'b0, QUIET},
      '{'{1'b0, 1'b1, 1'b0}, 20'd100,    1'b0, QUIET},
      '{'{1'b0, 1'b0, 1'b0}, 20'd1,      1'b0, QUIET},
      '{'{1'b0, 1'b0, 1'b1}, 20'd2,      1'b0, QUIET}
   };

   localparam logic [23:0] COUNT_TOP = 24'hFFFFFF;
   localparam logic [17:0] DIST_TOP  = 18'h3FFFF;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   durz_req_if req_bus ();
   durz_rsp_if rsp_bus ();

   dual_ultrasonic_range_zone dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   durz_cfg_type cfg;
   logic [2:0]   ph;
   logic [23:0]  tcount;
   logic [23:0]  ewidth;
   logic [17:0]  filt_main;
   logic [17:0]  filt_sub;
   logic [1:0]   zone;
   logic         sel;

   durz_rsp_type rsp_due [$];
   int faults;
   bit calm;
   bit squeeze_go;
   bit squeezed;
   int hold_left;
   logic [1:0] pin_level;
   int pin_left [2];

   function automatic bit tick_done(input logic [23:0] lim);
      if (tcount != COUNT_TOP) tcount++;
      return tcount >= lim || tcount == COUNT_TOP;
   endfunction

   function automatic logic [17:0] fold_echo(input logic [23:0] width);
      logic [39:0] prod;
      logic [17:0] dist_q;
      logic [35:0] a;
      logic [35:0] acc;
      logic [17:0] v;
      prod = 40'(width) * 40'(cfg.tick_scale);
      dist_q = (prod[39:16] > 24'(DIST_TOP)) ? DIST_TOP : prod[33:16];
      a = (cfg.ema_alpha > ALPHA_ONE) ? 36'(ALPHA_ONE) : 36'(cfg.ema_alpha);
      acc = a * 36'(dist_q) + (36'd256 - a) * 36'(sel ? filt_sub : filt_main) + 36'd128;
      v = (acc[35:8] > 28'(DIST_TOP)) ? DIST_TOP : acc[25:8];
      if (sel) filt_sub = v;
      else filt_main = v;
      if (v <= {cfg.near_limit_cm, 8'h00}) zone = ZONE_NEAR;
      else if (v <= {cfg.mid_limit_cm, 8'h00}) zone = ZONE_MIDDLE;
      else if (v <= {cfg.far_limit_cm, 8'h00}) zone = ZONE_FAR;
      else begin
         zone = ZONE_CLEAR;
         sel = ~sel;
      end
      tcount = '0;
      ewidth = '0;
      ph = (cfg.gap_ticks != '0) ? PH_GAP : PH_IDLE;
      return v;
   endfunction

   function automatic durz_rsp_type predict_tick(input durz_req_type b);
      durz_rsp_type r;
      logic echo;
      r = '0;
      echo = sel ? b.echo_sub : b.echo_main;
      case (ph)
         PH_IDLE: begin
            if (!b.accel_inhibit) begin
               ph = PH_TRIG_MAIN;
               tcount = '0;
            end
         end
         PH_TRIG_MAIN: begin
            r.trig_main = 1'b1;
            if (tick_done(24'(cfg.trigger_ticks))) begin
               ph = PH_TRIG_SUB;
               tcount = '0;
            end
         end
         PH_TRIG_SUB: begin
            r.trig_sub = 1'b1;
            if (tick_done(24'(cfg.trigger_ticks))) begin
               ph = PH_WAIT;
               tcount = '0;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               ewidth = 24'd1;
               ph = PH_ECHO;
            end else if (tick_done(cfg.echo_timeout_ticks)) begin
               r.result_valid = 1'b1;
               r.timed_out = 1'b1;
               r.measured_sensor = sel;
               r.filtered_distance = fold_echo('0);
            end
         end
         PH_ECHO: begin
            if (echo) begin
               if (ewidth != COUNT_TOP) ewidth++;
            end else begin
               r.result_valid = 1'b1;
               r.measured_sensor = sel;
               r.filtered_distance = fold_echo(ewidth);
            end
         end
         PH_GAP: begin
            if (tick_done(cfg.gap_ticks)) begin
               ph = PH_IDLE;
               tcount = '0;
            end
         end
         default: begin
            ph = PH_IDLE;
            tcount = '0;
         end
      endcase
      r.obstacle_zone = zone;
      r.sensor_select = sel;
      return r;
   endfunction

   function automatic string show(input durz_rsp_type r);
      return $sformatf("trig %0b/%0b valid %0b tout %0b sensor %0b dist %0d zone %0d select %0b",
                       r.trig_main, r.trig_sub, r.result_valid, r.timed_out,
                       r.measured_sensor, r.filtered_distance, r.obstacle_zone,
                       r.sensor_select);
   endfunction

   task automatic note_fault(input string what);
      faults++;
      if (faults <= 10) $display("%0t: %s", $time, what);
   endtask

   task automatic offer(input durz_req_type b, input logic typed, input durz_rsp_type want);
      int gap;
      durz_rsp_type r;
      if (!calm && $urandom_range(0, 23) == 0) begin
         gap = $urandom_range(1, 16);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.echo_main <= b.echo_main;
      req_bus.echo_sub <= b.echo_sub;
      req_bus.accel_inhibit <= b.accel_inhibit;
      do @(posedge clock); while (!req_bus.ready);
      r = predict_tick(b);
      rsp_due.push_back(typed ? want : r);
   endtask

   task automatic poke(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input durz_cfg_type c);
      poke(CSR_TRIGGER_TICKS, 24'(c.trigger_ticks));
      poke(CSR_ECHO_TIMEOUT, c.echo_timeout_ticks);
      poke(CSR_GAP_TICKS, c.gap_ticks);
      poke(CSR_TICK_SCALE, 24'(c.tick_scale));
      poke(CSR_EMA_ALPHA, 24'(c.ema_alpha));
      poke(CSR_NEAR_LIMIT, 24'(c.near_limit_cm));
      poke(CSR_MID_LIMIT, 24'(c.mid_limit_cm));
      poke(CSR_FAR_LIMIT, 24'(c.far_limit_cm));
      csr_we <= 1'b0;
      cfg = c;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic durz_req_type draw_beat();
      durz_req_type b;
      for (int p = 0; p < 2; p++) begin
         if (pin_left[p] == 0) begin
            pin_level[p] = ~pin_level[p];
            if (!pin_level[p]) pin_left[p] = $urandom_range(1, 30);
            else if ($urandom_range(0, 15) == 0) pin_left[p] = $urandom_range(200, 700);
            else pin_left[p] = $urandom_range(1, 40);
         end
         pin_left[p]--;
      end
      b.echo_main = pin_level[0];
      b.echo_sub = pin_level[1];
      b.accel_inhibit = ($urandom_range(0, 15) == 0);
      return b;
   endfunction

   always @(posedge clock) begin
      if (squeeze_go && !squeezed) begin
         squeezed = 1'b1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 23) == 0) begin
         hold_left = $urandom_range(0, 15);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      durz_rsp_type seen;
      durz_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{rsp_bus.trig_main, rsp_bus.trig_sub, rsp_bus.result_valid,
                  rsp_bus.timed_out, rsp_bus.measured_sensor, rsp_bus.filtered_distance,
                  rsp_bus.obstacle_zone, rsp_bus.sensor_select};
         if (rsp_due.size() == 0) begin
            note_fault($sformatf("unexpected beat: %s", show(seen)));
         end else begin
            want = rsp_due.pop_front();
            if (seen !== want)
               note_fault($sformatf("mismatch: expected %s, got %s", show(want), show(seen)));
         end
      end
   end

   initial begin
      #100_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      durz_cfg_type c;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TRIGGER_TICKS;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.echo_main = 1'b0;
      req_bus.echo_sub = 1'b0;
      req_bus.accel_inhibit = 1'b0;
      rsp_bus.ready = 1'b0;
      cfg = '{RST_TRIGGER_TICKS, RST_ECHO_TIMEOUT, RST_GAP_TICKS, RST_TICK_SCALE,
              RST_EMA_ALPHA, RST_NEAR_LIMIT, RST_MID_LIMIT, RST_FAR_LIMIT};
      ph = PH_IDLE;
      tcount = '0;
      ewidth = '0;
      filt_main = '0;
      filt_sub = '0;
      zone = ZONE_CLEAR;
      sel = 1'b0;
      pin_level = '0;
      pin_left = '{0, 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_settings('{16'd1, 24'd1, 24'd0, 16'hFFFF, ALPHA_ONE, 10'd0, 10'd1, 10'd2});
      foreach (DRILL[r]) begin
         for (int n = 0; n < DRILL[r].reps; n++)
            offer(DRILL[r].beat, DRILL[r].typed, DRILL[r].want);
      end
      settle();

      for (int k = 0; k < 6; k++) begin
         if (k == 0) begin
            c = '1;
         end else if (k == 1) begin
            c = '0;
         end else begin
            c.trigger_ticks = 16'($urandom_range(0, 3));
            c.echo_timeout_ticks = 24'($urandom_range(0, 48));
            c.gap_ticks = $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(1, 8));
            c.tick_scale = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
            c.ema_alpha = 9'($urandom_range(0, 511));
            if ($urandom_range(0, 3) == 0) begin
               c.near_limit_cm = 10'($urandom);
               c.mid_limit_cm = 10'($urandom);
               c.far_limit_cm = 10'($urandom);
            end else begin
               c.near_limit_cm = 10'($urandom_range(0, 2));
               c.mid_limit_cm = 10'($urandom_range(0, 2));
               c.far_limit_cm = 10'($urandom_range(0, 2));
            end
         end
         load_settings(c);
         if (k == 3) squeeze_go <= 1'b1;
         repeat (125) offer(draw_beat(), 1'b0, QUIET);
         settle();
      end

      calm <= 1'b1;
      load_settings('{16'd1, 24'd20, 24'd2, 16'hFFFF, 9'd128, 10'd0, 10'd1, 10'd2});
      repeat (250) offer(draw_beat(), 1'b0, QUIET);
      settle();
      repeat (8) @(posedge clock);

      if (faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
